/* hdl/bmcr_pkg.sv */
package bmcr_pkg;

  localparam int ModuleSlotsDefault = 16;
  localparam int CellsPerModule     = 12;
  localparam int SensorsPerModule   = 6;
  localparam int Modules            = 16;
  localparam int SlotTemp           = CellsPerModule + SensorsPerModule;
  localparam int SlotBal            = SlotTemp + 1;
  localparam int SlotFault          = SlotTemp + 2;
  localparam int SlotTotal          = SlotTemp + 3;
  localparam int Slots              = SlotTemp + 4;
  localparam int SlotWidth          = 5;
  localparam int DataDepth          = Modules * 32;
  localparam int DataAddrWidth      = 9;
  localparam int RunFrames          = 13;

  localparam logic [10:0] UnlockId   = 11'h7e0;
  localparam logic [10:0] ReplyId    = 11'h600;
  localparam logic [10:0] ReqMask    = 11'he00;
  localparam logic [10:0] ReqBase    = 11'h400;
  localparam logic [7:0]  KeyHi      = 8'hbe;
  localparam logic [7:0]  KeyLo      = 8'hdc;
  localparam logic [7:0]  SetCmd     = 8'h15;
  localparam logic [7:0]  PackedMark = 8'hAA;

  localparam logic [1:0] StageIdle = 2'd0;
  localparam logic [1:0] StageReq  = 2'd1;
  localparam logic [1:0] StageKey  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DERIVE,
    ST_SCAN,
    ST_SEND,
    ST_RUN_READ,
    ST_RUN_WAIT,
    ST_RUN_SEND
  } state_e;

  function automatic logic [3:0] table_reset(input logic [3:0] i);
    logic [3:0] r;
    case (i)
      4'd0: r = 4'h0;   4'd1: r = 4'h1;   4'd2: r = 4'h3;   4'd3: r = 4'h2;
      4'd4: r = 4'h8;   4'd5: r = 4'h9;   4'd6: r = 4'hB;   4'd7: r = 4'hA;
      4'd8: r = 4'hC;   4'd9: r = 4'hD;   4'd10: r = 4'hF;  4'd11: r = 4'hE;
      4'd12: r = 4'h4;  4'd13: r = 4'h5;  4'd14: r = 4'h7;  default: r = 4'h6;
    endcase
    return r;
  endfunction

endpackage

/* hdl/bmcr_ram.sv */
module bmcr_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/battery_module_can_responder.sv */
// Battery module CAN responder. Received frames (operation 0) and measurement
// writes (operation 1) come in on the input channel; reply and data frames
// leave on the output channel. Measurements live in a 512-word RAM, one row of
// 32 words per module, read one word per cycle. After reset a clearing pass
// zeroes the whole RAM; no item is accepted meanwhile. A measurement write or
// ignored frame is handled in the idle state, an unlock frame goes through a
// send state for its reply, a set command through derive and send states, a
// request for a new module through a table scan, and a full response run
// reads the module's measurements from RAM and then sends 13 frames, each
// held while the output is stalled.
module battery_module_can_responder
  import bmcr_pkg::*;
#(
  parameter int ModuleSlots = ModuleSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [10:0] frame_id_i,
  input  logic [63:0] frame_data_i,
  input  logic [3:0]  meas_module_i,
  input  logic [4:0]  meas_slot_i,
  input  logic [15:0] meas_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] tx_id_o,
  output logic [63:0] tx_data_o,
  output logic        last_frame_o
);

  localparam int CntW = $clog2(ModuleSlots + 1);

  state_e state_q, state_d;
  logic [1:0]  stage_q, stage_d;
  logic [3:0]  active_q, active_d;
  logic [3:0]  mask_q, mask_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]  tbl_q [ModuleSlots];
  logic [7:0]  tbl_d [ModuleSlots];
  logic [DataAddrWidth-1:0] clr_q, clr_d;
  logic [4:0]  idx_q, idx_d;
  logic [3:0]  nm_q, nm_d;
  logic [3:0]  low_q, low_d;
  logic        hit_q, hit_d;
  logic [15:0] w_q [Slots];
  logic [15:0] w_d [Slots];
  logic [3:0]  frame_q, frame_d;
  logic        ov_q, ov_d;
  logic [10:0] tid_q, tid_d;
  logic [63:0] tdat_q, tdat_d;
  logic        tlast_q, tlast_d;
  logic signed [15:0] mx_q, mx_d, mn_q, mn_d, tmx_q, tmx_d, tmn_q, tmn_d;

  logic        ram_we;
  logic [DataAddrWidth-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  bmcr_ram #(.Width(16), .Depth(DataDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [7:0] r [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      r[k] = frame_data_i[63-8*k -: 8];
    end
  end

  logic accept;
  assign in_stall_o = (state_q != ST_IDLE) || ov_q;
  assign accept     = in_valid_i && !in_stall_o;

  function automatic logic [63:0] run_frame(input logic [3:0] n, input logic [15:0] w [Slots],
                                            input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c, input logic [15:0] d);
    logic [63:0] f;
    logic [3:0] off;
    f = '0;
    off = '0;
    case (n)
      4'd4: f = {a, b, w[SlotTemp][7:0], w[SlotBal], w[SlotFault][7:0]};
      4'd11: f = {w[0], 16'h0, w[SlotTotal], w[SlotTotal]};
      4'd12: f = {{2{w[12][7:0]}}, {2{w[13][7:0]}}, {2{w[14][7:0]}}, {2{w[15][7:0]}}};
      4'd13: f = {{2{w[16][7:0]}}, {2{w[17][7:0]}}, c[7:0], d[7:0], 8'h00, 8'd13};
      default: begin
        if (n <= 4'd3) off = (n - 4'd1) << 2;
        else if (n <= 4'd7) off = (n - 4'd5) << 2;
        else off = (n - 4'd8) << 2;
        f = {w[off], w[off+4'd1], w[off+4'd2], w[off+4'd3]};
      end
    endcase
    return f;
  endfunction

  always_comb begin
    state_d = state_q; stage_d = stage_q; active_d = active_q; mask_d = mask_q;
    count_d = count_q; tbl_d = tbl_q; clr_d = clr_q; idx_d = idx_q;
    nm_d = nm_q; low_d = low_q; hit_d = hit_q; w_d = w_q; frame_d = frame_q;
    ov_d = ov_q; tid_d = tid_q; tdat_d = tdat_q; tlast_d = tlast_q;
    mx_d = mx_q; mn_d = mn_q; tmx_d = tmx_q; tmn_d = tmn_q;
    ram_we = 1'b0; ram_waddr = clr_q; ram_wdata = '0;
    ram_raddr = {active_q, idx_q};

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == DataAddrWidth'(DataDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (operation_i) begin
            if (meas_slot_i < SlotWidth'(Slots)) begin
              ram_we = 1'b1;
              ram_waddr = {meas_module_i, meas_slot_i};
              ram_wdata = meas_value_i;
            end
          end else if (frame_id_i == UnlockId && r[0] == 8'h0d && r[1] == 8'h01) begin
            stage_d = StageReq;
            tid_d = ReplyId; tdat_d = 64'h0d01aa1234000000; tlast_d = 1'b1;
            state_d = ST_SEND;
          end else if (frame_id_i == UnlockId && r[0] == 8'h0d && r[1] == 8'h02 &&
                       r[2] == KeyHi && r[3] == KeyLo && stage_q == StageReq) begin
            stage_d = StageKey;
            tid_d = ReplyId; tdat_d = 64'h0d02aa0000000000; tlast_d = 1'b1;
            state_d = ST_SEND;
          end else if (frame_id_i == UnlockId && r[0] == 8'h04 && r[1] == SetCmd &&
                       stage_q == StageKey) begin
            stage_d = StageIdle;
            if (r[7] == PackedMark) begin
              if ({1'b0, r[2]} * 9'd2 > 9'(ModuleSlots)) count_d = CntW'(ModuleSlots);
              else count_d = CntW'({r[2], 1'b0});
              for (int k = 0; k < 4; k++) begin
                if (4 * k < ModuleSlots) tbl_d[4*k] = {4'h0, r[3+k][7:4]};
                if (4 * k + 2 < ModuleSlots) tbl_d[4*k+2] = {4'h0, r[3+k][3:0]};
              end
              state_d = ST_DERIVE;
            end else if (r[3] == 8'h0 && r[4] == 8'h0 && r[5] == 8'h0 &&
                         r[6] == 8'h0 && r[7] == 8'h0) begin
              count_d = CntW'(2);
              tbl_d[0] = r[2];
              state_d = ST_DERIVE;
            end
          end else if ((frame_id_i & ReqMask) == ReqBase) begin
            nm_d = frame_id_i[8:5];
            low_d = frame_id_i[3:0];
            hit_d = 1'b0;
            idx_d = '0;
            if (active_q != frame_id_i[8:5]) state_d = ST_SCAN;
            else begin
              mask_d = mask_q;
              case (frame_id_i[3:0])
                4'h6: mask_d[0] = 1'b1;
                4'ha: mask_d[1] = 1'b1;
                4'hb: mask_d[2] = 1'b1;
                4'hc: mask_d[3] = 1'b1;
                default: ;
              endcase
              if (mask_d == 4'hf) begin
                mask_d = '0; idx_d = '0; state_d = ST_RUN_READ;
              end
            end
          end
        end
      end
      ST_DERIVE: begin
        for (int k = 0; k + 1 < ModuleSlots; k += 2) begin
          tbl_d[k+1] = tbl_q[k][0] ? tbl_q[k] - 8'd1 : tbl_q[k] + 8'd1;
        end
        tid_d = ReplyId; tdat_d = 64'h0415aa0000000000; tlast_d = 1'b1;
        state_d = ST_SEND;
      end
      ST_SCAN: begin
        if (idx_q < 5'(ModuleSlots) && {1'b0, idx_q} < 6'(count_q)) begin
          if (tbl_q[idx_q[3:0]] == {4'h0, nm_q}) hit_d = 1'b1;
          idx_d = idx_q + 5'd1;
        end else begin
          mask_d = '0;
          if (hit_q) begin
            active_d = nm_q;
            case (low_q)
              4'h6: mask_d[0] = 1'b1;
              4'ha: mask_d[1] = 1'b1;
              4'hb: mask_d[2] = 1'b1;
              4'hc: mask_d[3] = 1'b1;
              default: ;
            endcase
          end
          state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RUN_READ: begin
        ram_raddr = {active_q, idx_q};
        mx_d = -16'sh7fff; mn_d = 16'sh7fff; tmx_d = -16'sh7fff; tmn_d = 16'sh7fff;
        state_d = ST_RUN_WAIT;
      end
      ST_RUN_WAIT: begin
        w_d[idx_q] = ram_rdata;
        if (idx_q < 5'(CellsPerModule)) begin
          if ($signed(ram_rdata) > mx_q) mx_d = $signed(ram_rdata);
          if ($signed(ram_rdata) < mn_q) mn_d = $signed(ram_rdata);
        end else if (idx_q < 5'(SlotTemp)) begin
          if ($signed({1'b0, ram_rdata}) > $signed({tmx_q[15], tmx_q}))
            tmx_d = $signed(ram_rdata);
          if ($signed({1'b0, ram_rdata}) < $signed({tmn_q[15], tmn_q}))
            tmn_d = $signed(ram_rdata);
        end
        if (idx_q == 5'(Slots - 1)) begin
          frame_d = 4'd1;
          state_d = ST_RUN_SEND;
        end else begin
          idx_d = idx_q + 5'd1;
          ram_raddr = {active_q, idx_q + 5'd1};
        end
      end
      ST_RUN_SEND: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          tid_d = {2'b00, active_q, 1'b0, frame_q};
          tdat_d = run_frame(frame_q, w_q, mx_q, mn_q, tmx_q, tmn_q);
          tlast_d = (frame_q == 4'(RunFrames));
          frame_d = frame_q + 4'd1;
          if (frame_q == 4'(RunFrames)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      stage_q <= StageIdle;
      active_q <= '0;
      mask_q <= '0;
      count_q <= CntW'(ModuleSlots);
      clr_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < ModuleSlots; i++) begin
        tbl_q[i] <= {4'h0, table_reset(4'(i))};
      end
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      active_q <= active_d;
      mask_q <= mask_d;
      count_q <= count_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      tbl_q <= tbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    nm_q <= nm_d;
    low_q <= low_d;
    hit_q <= hit_d;
    w_q <= w_d;
    frame_q <= frame_d;
    tid_q <= tid_d;
    tdat_q <= tdat_d;
    tlast_q <= tlast_d;
    mx_q <= mx_d;
    mn_q <= mn_d;
    tmx_q <= tmx_d;
    tmn_q <= tmn_d;
  end

  assign out_valid_o  = ov_q;
  assign tx_id_o      = tid_q;
  assign tx_data_o    = tdat_q;
  assign last_frame_o = tlast_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !accept) else $error("accepted while busy");
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd3) else $error("bad unlock stage");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ModuleSlots)) else $error("module count overflow");
  a_mask_clear_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN_SEND) |-> mask_q == 4'h0) else $error("mask not cleared");
`endif

endmodule
